FILE: src/rch_pkg.sv
// Package for the windowed colour histogram: types, codes and constants.
`default_nettype none

package rch_pkg;

	localparam int BINS_DEF       = 256;
	localparam int COUNT_BITS_DEF = 20;
	localparam int CFG_W          = 10;
	localparam int CFG_IDX_W      = 3;
	localparam int QUEUE_DEPTH    = 4;
	localparam int OUT_COUNT_W    = 20;
	localparam int NORM_W         = 17;
	localparam int FRAC_BITS      = 16;
	localparam int DIV_W          = 2 * CFG_W;
	localparam int OUT_COUNT_MAX  = (1 << OUT_COUNT_W) - 1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST   = 10'd320;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST  = 10'd240;
	localparam logic [CFG_W-1:0] CENTER_X_RST      = 10'd160;
	localparam logic [CFG_W-1:0] CENTER_Y_RST      = 10'd120;
	localparam logic [CFG_W-1:0] WINDOW_WIDTH_RST  = 10'd80;
	localparam logic [CFG_W-1:0] WINDOW_HEIGHT_RST = 10'd60;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PIXEL = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_CENTER_X      = 3'd2,
		REG_CENTER_Y      = 3'd3,
		REG_WINDOW_WIDTH  = 3'd4,
		REG_WINDOW_HEIGHT = 3'd5
	} cfg_index_t;

	typedef enum logic [1:0] {
		TASK_CLEAR = 2'd0,
		TASK_BUMP  = 2'd1,
		TASK_READ  = 2'd2
	} task_t;

	typedef enum logic [2:0] {
		BK_CLEAR  = 3'd0,
		BK_IDLE   = 3'd1,
		BK_FETCH  = 3'd2,
		BK_DIVIDE = 3'd3,
		BK_RESULT = 3'd4
	} back_state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] channel_select;
		logic [7:0] bin_select;
	} cmd_t;

	typedef struct packed {
		logic [OUT_COUNT_W-1:0] bin_count;
		logic [NORM_W-1:0]      bin_normalised;
		logic                   divide_error;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] frame_width;
		logic [CFG_W-1:0] frame_height;
		logic [CFG_W-1:0] center_x;
		logic [CFG_W-1:0] center_y;
		logic [CFG_W-1:0] window_width;
		logic [CFG_W-1:0] window_height;
	} cfg_t;

	typedef struct packed {
		task_t      kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] channel_select;
		logic [7:0] bin_select;
	} work_t;

endpackage

`default_nettype wire

FILE: src/rch_front.sv
// Front end: takes commands, tracks the raster position and tests the window.
`default_nettype none

module rch_front (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cmd_valid,
	output logic            cmd_stall,
	input  rch_pkg::cmd_t   cmd,
	input  rch_pkg::cfg_t   cfg,
	input  wire             q_full,
	input  wire             init,
	output logic            push,
	output rch_pkg::work_t  push_work
);
	import rch_pkg::*;

	logic [CFG_W-1:0]   col_q;
	logic [CFG_W-1:0]   row_q;
	logic               seen_q;
	logic               accept;
	logic               in_frame;
	logic               line_end;
	logic               hit;
	logic signed [11:0] row_s, col_s, lo, hi, left, right;

	assign cmd_stall = q_full || init;
	assign accept    = cmd_valid && !cmd_stall;

	assign row_s = signed'({2'b00, row_q});
	assign col_s = signed'({2'b00, col_q});
	assign lo    = signed'({2'b00, cfg.center_y} - {3'b000, cfg.window_height[CFG_W-1:1]});
	assign hi    = signed'({2'b00, cfg.center_y} + {3'b000, cfg.window_height[CFG_W-1:1]});
	assign left  = signed'({2'b00, cfg.center_x} - {3'b000, cfg.window_width[CFG_W-1:1]});
	assign right = signed'({2'b00, cfg.center_x} + {3'b000, cfg.window_width[CFG_W-1:1]});

	assign in_frame = row_q < cfg.frame_height;
	assign line_end = ({1'b0, col_q} + 11'd1) >= {1'b0, cfg.frame_width};
	assign hit      = seen_q && (row_s >= lo) && (row_s < hi) && (col_s > left) && (col_s < right);

	always_comb begin
		push                     = 1'b0;
		push_work.kind           = TASK_BUMP;
		push_work.red            = cmd.red;
		push_work.green          = cmd.green;
		push_work.blue           = cmd.blue;
		push_work.channel_select = cmd.channel_select;
		push_work.bin_select     = cmd.bin_select;
		if (accept) begin
			unique case (cmd.opcode)
				OP_CLEAR: begin
					push           = 1'b1;
					push_work.kind = TASK_CLEAR;
				end
				OP_PIXEL: begin
					push           = in_frame && hit;
					push_work.kind = TASK_BUMP;
				end
				OP_READ: begin
					push           = 1'b1;
					push_work.kind = TASK_READ;
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			if (cmd.opcode == OP_CLEAR) begin
				col_q  <= '0;
				row_q  <= '0;
				seen_q <= 1'b0;
			end else if (cmd.opcode == OP_PIXEL && in_frame) begin
				seen_q <= 1'b1;
				if (line_end) begin
					col_q <= '0;
					row_q <= row_q + 10'd1;
				end else begin
					col_q <= col_q + 10'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/rch_queue.sv
// Short queue of classified work between the front and back ends.
`default_nettype none

module rch_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  rch_pkg::work_t  push_data,
	input  wire             pop,
	output rch_pkg::work_t  head,
	output logic            full,
	output logic            empty
);
	import rch_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	work_t       entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   fill_q;
	logic          do_push;
	logic          do_pop;

	assign full    = fill_q == (PW + 1)'(QUEUE_DEPTH);
	assign empty   = fill_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (PW + 1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (PW + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/rch_back.sv
// Back end: bin memories, pipelined increment, clearing sweep and bin read with divide.
`default_nettype none

module rch_back #(
	parameter int BINS       = rch_pkg::BINS_DEF,
	parameter int COUNT_BITS = rch_pkg::COUNT_BITS_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  rch_pkg::work_t  head,
	input  wire             q_empty,
	output logic            pop,
	input  rch_pkg::cfg_t   cfg,
	output logic            rsp_valid,
	input  wire             rsp_stall,
	output rch_pkg::rsp_t   rsp,
	output logic            init
);
	import rch_pkg::*;

	localparam int BA = $clog2(BINS);
	localparam int CW = (COUNT_BITS > DIV_W + 1) ? COUNT_BITS : DIV_W + 1;
	localparam int SW = $clog2(FRAC_BITS + 1);

	function automatic logic [BA-1:0] bin_of(input logic [7:0] v);
		logic [16:0] prod;
		prod = 17'(v) * 17'(BINS);
		return prod[BA+7:8];
	endfunction

	back_state_t          state_q, next_state;
	logic [BA-1:0]        sweep_q;
	logic                 init_q;
	logic                 head_bump;
	logic                 sweep_done;

	logic                 valid_s1;
	logic [BA-1:0]        addr_s1  [3];
	logic                 fwd_v_q;
	logic [BA-1:0]        fwd_addr_q [3];
	logic [COUNT_BITS-1:0] fwd_data_q [3];

	logic [7:0]           chan_byte [3];
	logic [BA-1:0]        rd_addr  [3];
	logic [COUNT_BITS-1:0] rdata_q [3];
	logic [COUNT_BITS-1:0] bumped  [3];
	logic                 wr_en;
	logic                 clearing;

	logic [1:0]           chan_q;
	logic                 hit_q;
	logic [COUNT_BITS-1:0] sel_count;
	logic [COUNT_BITS-1:0] count_q;
	logic [DIV_W-1:0]     rem_q;
	logic [NORM_W-1:0]    quo_q;
	logic [SW-1:0]        step_q;
	logic                 err_q;
	logic                 sat_q;
	logic                 sat_now;
	logic [DIV_W-1:0]     div_q;
	logic                 div_zero_q;
	logic [DIV_W:0]       trial;
	logic                 trial_ge;
	logic [DIV_W:0]       trial_sub;

	assign init       = init_q;
	assign head_bump  = head.kind == TASK_BUMP;
	assign sweep_done = sweep_q == BA'(BINS - 1);
	assign chan_byte[0] = head.red;
	assign chan_byte[1] = head.green;
	assign chan_byte[2] = head.blue;

	// The divisor only changes with configuration, so it is simply refreshed every cycle.
	always_ff @(posedge clk) begin
		div_q      <= DIV_W'({10'b0, cfg.window_width} * {10'b0, cfg.window_height - 10'd1});
		div_zero_q <= (cfg.window_height < 10'd2) || (cfg.window_width == '0);
	end

	// Next state.
	always_comb begin
		next_state = state_q;
		unique case (state_q)
			BK_CLEAR: if (sweep_done) next_state = BK_IDLE;
			BK_IDLE: begin
				if (pop && head.kind == TASK_CLEAR) begin
					next_state = BK_CLEAR;
				end else if (pop && head.kind == TASK_READ) begin
					next_state = BK_FETCH;
				end
			end
			BK_FETCH: begin
				if (div_zero_q || sat_now) begin
					next_state = BK_RESULT;
				end else begin
					next_state = BK_DIVIDE;
				end
			end
			BK_DIVIDE: if (step_q == '0) next_state = BK_RESULT;
			BK_RESULT: if (!rsp_stall) next_state = BK_IDLE;
			default: next_state = BK_IDLE;
		endcase
	end

	// Outputs. Anything but an increment waits for the increment pipeline to drain,
	// so that its memory read never overlaps an outstanding write.
	always_comb begin
		pop       = 1'b0;
		rsp_valid = 1'b0;
		clearing  = 1'b0;
		unique case (state_q)
			BK_CLEAR:  clearing  = 1'b1;
			BK_IDLE:   pop       = !q_empty && (head_bump || !valid_s1);
			BK_RESULT: rsp_valid = 1'b1;
			BK_FETCH, BK_DIVIDE: pop = 1'b0;
			default: pop = 1'b0;
		endcase
	end

	assign wr_en = valid_s1 || clearing;

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		logic [COUNT_BITS-1:0] mem [BINS];
		logic [COUNT_BITS-1:0] cur;
		logic [BA-1:0]         wr_addr;
		logic [COUNT_BITS-1:0] wr_data;

		assign rd_addr[ch] = head_bump ? bin_of(chan_byte[ch]) : head.bin_select[BA-1:0];

		// The write issued on the edge that fetched this word is not in the read data yet.
		assign cur = (fwd_v_q && fwd_addr_q[ch] == addr_s1[ch]) ? fwd_data_q[ch] : rdata_q[ch];
		assign bumped[ch] = (cur == '1) ? cur : cur + COUNT_BITS'(1);

		assign wr_addr = clearing ? sweep_q : addr_s1[ch];
		assign wr_data = clearing ? '0 : bumped[ch];

		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[wr_addr] <= wr_data;
			end
			rdata_q[ch] <= mem[rd_addr[ch]];
		end

		always_ff @(posedge clk) begin
			addr_s1[ch]    <= rd_addr[ch];
			fwd_addr_q[ch] <= addr_s1[ch];
			fwd_data_q[ch] <= bumped[ch];
		end
	end

	always_comb begin
		unique case (chan_q)
			2'd0:    sel_count = rdata_q[0];
			2'd1:    sel_count = rdata_q[1];
			2'd2:    sel_count = rdata_q[2];
			default: sel_count = '0;
		endcase
		if (!hit_q) begin
			sel_count = '0;
		end
	end

	// The quotient fits in its field exactly when count < 2 * divisor.
	assign sat_now = CW'(sel_count) >= (CW'(div_q) << 1);

	assign trial     = {rem_q, (step_q == SW'(FRAC_BITS)) ? count_q[0] : 1'b0};
	assign trial_ge  = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_CLEAR;
			init_q   <= 1'b1;
			sweep_q  <= '0;
			valid_s1 <= 1'b0;
			fwd_v_q  <= 1'b0;
		end else begin
			state_q  <= next_state;
			valid_s1 <= pop && head_bump;
			fwd_v_q  <= valid_s1;
			if (clearing) begin
				if (sweep_done) begin
					sweep_q <= '0;
					init_q  <= 1'b0;
				end else begin
					sweep_q <= sweep_q + BA'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.kind == TASK_READ) begin
			chan_q <= head.channel_select;
			hit_q  <= (head.channel_select != 2'd3) && ({1'b0, head.bin_select} < 9'(BINS));
		end
		if (state_q == BK_FETCH) begin
			count_q <= sel_count;
			rem_q   <= DIV_W'(sel_count >> 1);
			quo_q   <= '0;
			step_q  <= SW'(FRAC_BITS);
			err_q   <= div_zero_q;
			sat_q   <= sat_now;
		end else if (state_q == BK_DIVIDE) begin
			rem_q  <= trial_ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q  <= {quo_q[NORM_W-2:0], trial_ge};
			step_q <= step_q - SW'(1);
		end
	end

	assign rsp.bin_count = (CW'(count_q) > CW'(OUT_COUNT_MAX)) ? '1 : OUT_COUNT_W'(count_q);
	assign rsp.bin_normalised = err_q ? '0 : (sat_q ? '1 : quo_q);
	assign rsp.divide_error   = err_q;

endmodule

`default_nettype wire

FILE: src/roi_color_histogram.sv
// Top level of the windowed three-channel colour histogram.
//
//  Channel | Direction | Handshake            | Payload
//  cmd     | in        | cmd_valid, cmd_stall | rch_pkg::cmd_t (opcode, colour bytes, read select)
//  rsp     | out       | rsp_valid, rsp_stall | rch_pkg::rsp_t (count, normalised count, error)
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// Pixels are taken one per cycle while cmd_stall is low; the bin increment is a pipelined
// read-modify-write on one memory per channel, with forwarding between back-to-back pixels.
// A clear sweeps the bin memories at one row per cycle.
// A read: memory read, select, 17 divide steps, result; saturated or error reads skip the divide.
// After reset the same clearing pass runs while cmd_stall is held high.
// A four-entry queue sits between the front and back ends, so commands keep being taken
// while a read is dividing or its result waits for transfer, until the queue fills.
`default_nettype none

module roi_color_histogram #(
	parameter int BINS       = rch_pkg::BINS_DEF,
	parameter int COUNT_BITS = rch_pkg::COUNT_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cmd_valid,
	output logic                             cmd_stall,
	input  rch_pkg::cmd_t                    cmd,
	output logic                             rsp_valid,
	input  wire                              rsp_stall,
	output rch_pkg::rsp_t                    rsp,
	input  wire                              cfg_we,
	input  wire [rch_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [rch_pkg::CFG_W-1:0]         cfg_data
);
	import rch_pkg::*;

	cfg_t  cfg_q;
	logic  push;
	work_t push_work;
	work_t head;
	logic  q_full;
	logic  q_empty;
	logic  pop;
	logic  init;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= FRAME_WIDTH_RST;
			cfg_q.frame_height  <= FRAME_HEIGHT_RST;
			cfg_q.center_x      <= CENTER_X_RST;
			cfg_q.center_y      <= CENTER_Y_RST;
			cfg_q.window_width  <= WINDOW_WIDTH_RST;
			cfg_q.window_height <= WINDOW_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data;
				REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data;
				REG_CENTER_X:      cfg_q.center_x      <= cfg_data;
				REG_CENTER_Y:      cfg_q.center_y      <= cfg_data;
				REG_WINDOW_WIDTH:  cfg_q.window_width  <= cfg_data;
				REG_WINDOW_HEIGHT: cfg_q.window_height <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	rch_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.init      (init),
		.push      (push),
		.push_work (push_work)
	);

	rch_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_work),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	rch_back #(
		.BINS       (BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.cfg       (cfg_q),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.init      (init)
	);

	// No result can appear before the clearing pass after reset has finished.
	a_no_rsp_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init |-> !rsp_valid)
		else $error("result offered during the reset clearing pass");

	a_err_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.divide_error) |-> (rsp.bin_normalised == '0))
		else $error("normalised count not zero on a divide error");

	// After a completed transfer the back end returns to idle, so a result is never offered again at once.
	a_rsp_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall) |=> !rsp_valid)
		else $error("result offered again right after a transfer");

endmodule

`default_nettype wire
